@@ rtl/mprp_pkg.sv @@
// Shared types and constants for the multicast probe rate picker.
// Holds config indexes, controller states and the command/status bundles.
// No dependencies.
`timescale 1ns / 1ps

package mprp_pkg;

  // Packet matching
  localparam logic [7:0]  UDP_PROTO      = 8'd17;

  // Configuration register reset values
  localparam logic [31:0] MATCH_ADDR_RST = 32'hC0A8_084C;
  localparam logic [6:0]  INTERVAL_RST   = 7'd100;
  localparam logic [6:0]  SHARE_RST      = 7'd70;
  localparam logic [31:0] SEED_RST       = 32'd1;

  localparam int          CFG_W          = 32;
  localparam int          CFG_IDX_W      = 2;

  // Random source: right-shifting Galois LFSR
  localparam logic [31:0] LFSR_TAPS      = 32'h8020_0003;

  // Sent count saturates here
  localparam logic [6:0]  COUNT_MAX      = 7'd127;

  // Share is clamped to whole percent
  localparam logic [6:0]  SHARE_MAX      = 7'd100;

  // Reciprocal constants: x/100 for x < 12800, y/3 for y < 128
  localparam logic [12:0] RECIP_100      = 13'd5243;
  localparam int          RECIP_100_SH   = 19;
  localparam logic [7:0]  RECIP_3        = 8'd171;
  localparam int          RECIP_3_SH     = 9;

  // IP id carries the rate in its top nibble
  localparam int          ID_SHIFT       = 12;

  // Remainder unit: 32-bit dividend, two bits a step
  localparam int          MOD_STEPS      = 16;
  localparam int          MOD_STEP_W     = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATCH_ADDR,
    CFG_FB_INTERVAL,
    CFG_PROBE_SHARE,
    CFG_RANDOM_SEED
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_Q_MUL,
    ST_Q_DIV100,
    ST_Q_DIV3,
    ST_Q_SET,
    ST_F_COUNT,
    ST_F_CHK,
    ST_F_MOD,
    ST_F_SEL,
    ST_P_CHK,
    ST_P_MOD,
    ST_P_SEL,
    ST_FINISH
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;          // latch input transfer
    logic iv_mul;        // share * interval
    logic iv_div100;     // main share quota
    logic iv_div3;       // side quota
    logic iv_init;       // write quotas and fixed table entries
    logic scan_count;    // count eligible rate, advance scan
    logic rnd_fill;      // draw for a table fill
    logic scan_sel;      // select k-th eligible rate, advance scan
    logic fill_zero;     // no eligible rate: write zero
    logic rnd_pick;      // draw for the packet pick
    logic pick_take;     // take the selected entry, spend its quota
    logic pick_default;  // use entry 0 without a draw
    logic emit;          // load the output register
  } mprp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic matched;
    logic interval_due;
    logic scan_last;
    logic scan_hit;
    logic cnt_zero;
    logic mod_done;
    logic slot_last;
    logic pick_skip;
    logic out_free;
  } mprp_sts_t;

endpackage

@@ rtl/mprp_mod.sv @@
// Iterative remainder unit: 32-bit dividend modulo a narrow divisor.
// Two quotient bits per cycle. Uses mprp_pkg.
`timescale 1ns / 1ps

module mprp_mod #(
  parameter int DIV_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [31:0]      dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] rem_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [mprp_pkg::MOD_STEP_W-1:0]   step_q;
  logic [31:0]                       opd_q;
  logic [DIV_W-1:0]                  div_q;
  logic [DIV_W-1:0]                  rem_q;
  logic [DIV_W-1:0]                  rem_d;

  // Two restoring steps on the running remainder
  always_comb begin
    logic [DIV_W:0] t;
    rem_d = rem_q;
    for (int b = 0; b < 2; b++) begin
      t = {rem_d, opd_q[31-b]};
      if (t >= {1'b0, div_q}) begin
        t = t - {1'b0, div_q};
      end
      rem_d = t[DIV_W-1:0];
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == mprp_pkg::MOD_STEP_W'(mprp_pkg::MOD_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Operand and remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      opd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      opd_q <= {opd_q[29:0], 2'b00};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/mprp_ctrl.sv @@
// Sequencer for the rate picker: interval set-up, table fills, packet pick.
// Drives mprp_cmd_t to the datapath, reads mprp_sts_t. Uses mprp_pkg.
`timescale 1ns / 1ps

module mprp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mprp_pkg::mprp_sts_t sts_i,
  output mprp_pkg::mprp_cmd_t cmd_o
);

  mprp_pkg::ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mprp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      mprp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mprp_pkg::ST_CHECK;
        end
      end
      mprp_pkg::ST_CHECK: begin
        if (!sts_i.matched) begin
          state_d = mprp_pkg::ST_FINISH;
        end else if (sts_i.interval_due) begin
          state_d = mprp_pkg::ST_Q_MUL;
        end else begin
          state_d = mprp_pkg::ST_P_CHK;
        end
      end
      mprp_pkg::ST_Q_MUL: begin
        cmd_o.iv_mul = 1'b1;
        state_d      = mprp_pkg::ST_Q_DIV100;
      end
      mprp_pkg::ST_Q_DIV100: begin
        cmd_o.iv_div100 = 1'b1;
        state_d         = mprp_pkg::ST_Q_DIV3;
      end
      mprp_pkg::ST_Q_DIV3: begin
        cmd_o.iv_div3 = 1'b1;
        state_d       = mprp_pkg::ST_Q_SET;
      end
      mprp_pkg::ST_Q_SET: begin
        cmd_o.iv_init = 1'b1;
        state_d       = mprp_pkg::ST_F_COUNT;
      end
      mprp_pkg::ST_F_COUNT: begin
        cmd_o.scan_count = 1'b1;
        if (sts_i.scan_last) begin
          state_d = mprp_pkg::ST_F_CHK;
        end
      end
      mprp_pkg::ST_F_CHK: begin
        if (sts_i.cnt_zero) begin
          cmd_o.fill_zero = 1'b1;
          state_d = sts_i.slot_last ? mprp_pkg::ST_P_CHK : mprp_pkg::ST_F_COUNT;
        end else begin
          cmd_o.rnd_fill = 1'b1;
          state_d        = mprp_pkg::ST_F_MOD;
        end
      end
      mprp_pkg::ST_F_MOD: begin
        if (sts_i.mod_done) begin
          state_d = mprp_pkg::ST_F_SEL;
        end
      end
      mprp_pkg::ST_F_SEL: begin
        cmd_o.scan_sel = 1'b1;
        if (sts_i.scan_hit) begin
          state_d = sts_i.slot_last ? mprp_pkg::ST_P_CHK : mprp_pkg::ST_F_COUNT;
        end
      end
      mprp_pkg::ST_P_CHK: begin
        if (sts_i.pick_skip) begin
          cmd_o.pick_default = 1'b1;
          state_d            = mprp_pkg::ST_FINISH;
        end else begin
          cmd_o.rnd_pick = 1'b1;
          state_d        = mprp_pkg::ST_P_MOD;
        end
      end
      mprp_pkg::ST_P_MOD: begin
        if (sts_i.mod_done) begin
          state_d = mprp_pkg::ST_P_SEL;
        end
      end
      mprp_pkg::ST_P_SEL: begin
        cmd_o.pick_take = 1'b1;
        state_d         = mprp_pkg::ST_FINISH;
      end
      mprp_pkg::ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = mprp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mprp_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/mprp_dp.sv @@
// Datapath of the rate picker: config registers, LFSR, rate table, quotas,
// scan counter and output register. Uses mprp_pkg and mprp_mod.
`timescale 1ns / 1ps

module mprp_dp #(
  parameter int MAX_RATE_INDEX = 15
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mprp_pkg::mprp_cmd_t                cmd_i,
  output mprp_pkg::mprp_sts_t                sts_o,
  input  logic                               cfg_we_i,
  input  logic [mprp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mprp_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic [7:0]                         in_protocol_i,
  input  logic [31:0]                        in_dest_addr_i,
  input  logic [3:0]                         in_default_rate_i,
  input  logic                               in_feedback_reset_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic                               out_matched_o,
  output logic [3:0]                         out_send_rate_o,
  output logic [15:0]                        out_ip_id_value_o,
  output logic                               out_interval_started_o
);

  localparam int RATE_W = $clog2(MAX_RATE_INDEX + 1);
  localparam int CNT_W  = $clog2(MAX_RATE_INDEX + 2);
  localparam logic [RATE_W-1:0] RATE_MAX = RATE_W'(MAX_RATE_INDEX);

  // Configuration and random source
  logic [31:0]       match_q;
  logic [6:0]        interval_q;
  logic [6:0]        share_q;
  logic [31:0]       lfsr_q;
  logic [31:0]       lfsr_next;

  // Per packet
  logic              matched_q;
  logic [RATE_W-1:0] d_q;
  logic [RATE_W-1:0] d_clamp;
  logic              started_q;
  logic [RATE_W-1:0] rate_q;

  // Interval state
  logic [6:0]        sent_q;
  logic [RATE_W-1:0] table_q [4];
  logic [6:0]        quota_q [4];
  logic              high_q;

  // Quota arithmetic
  logic [6:0]        share_c;
  logic [13:0]       prod_q;
  logic [26:0]       m100;
  logic [6:0]        q0_q;
  logic [6:0]        diff;
  logic [14:0]       m3;
  logic [5:0]        q1_q;
  logic [6:0]        q1x3;

  // Fill scan
  logic              slot3_q;
  logic              restricted_q;
  logic [RATE_W-1:0] r_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  k_q;
  logic              elig;
  logic              hit;
  logic              fill_wr;

  // Packet pick
  logic [2:0]        n_live;
  logic [1:0]        pick_sel;
  logic              pick_skip;

  // Remainder unit
  logic              mod_start;
  logic [CNT_W-1:0]  mod_div;
  logic              mod_done;
  logic [CNT_W-1:0]  mod_rem;

  // Output register
  logic              out_valid_q;
  logic              out_matched_q;
  logic [RATE_W-1:0] out_rate_q;
  logic              out_started_q;

  assign lfsr_next = {1'b0, lfsr_q[31:1]} ^ (lfsr_q[0] ? mprp_pkg::LFSR_TAPS : 32'd0);

  assign d_clamp = (32'(in_default_rate_i) > 32'(MAX_RATE_INDEX)) ? RATE_MAX
                                                                  : RATE_W'(in_default_rate_i);

  assign share_c = (share_q > mprp_pkg::SHARE_MAX) ? mprp_pkg::SHARE_MAX : share_q;
  assign m100    = 27'(prod_q) * 27'(mprp_pkg::RECIP_100);
  assign diff    = interval_q - q0_q;
  assign m3      = 15'(diff) * 15'(mprp_pkg::RECIP_3);
  assign q1x3    = 7'({q1_q, 1'b0}) + 7'(q1_q);

  // Rate r_q is free for the slot being filled
  always_comb begin
    elig = (r_q != table_q[0]) && (r_q != table_q[1]) &&
           (!slot3_q || (r_q != table_q[2]));
    if (restricted_q) begin
      elig = elig && (high_q ? (r_q > table_q[1]) : (r_q < table_q[1]));
    end
  end

  assign hit     = elig && (k_q == '0);
  assign fill_wr = cmd_i.fill_zero || (cmd_i.scan_sel && hit);

  // Entries with quota left and the k-th of them
  always_comb begin
    logic [2:0] seen;
    logic       found;
    seen     = '0;
    found    = 1'b0;
    pick_sel = '0;
    for (int i = 0; i < 4; i++) begin
      if (quota_q[i] != '0) begin
        if (!found && (seen == 3'(k_q))) begin
          pick_sel = 2'(i);
          found    = 1'b1;
        end
        seen = seen + 3'd1;
      end
    end
    n_live = seen;
  end

  assign pick_skip = (sent_q >= interval_q) || (n_live == '0);

  assign mod_start = cmd_i.rnd_fill || cmd_i.rnd_pick;
  assign mod_div   = cmd_i.rnd_fill ? cnt_q : CNT_W'(n_live);

  mprp_mod #(
    .DIV_W (CNT_W)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (lfsr_next),
    .divisor_i  (mod_div),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // Configuration writes and LFSR steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q    <= mprp_pkg::MATCH_ADDR_RST;
      interval_q <= mprp_pkg::INTERVAL_RST;
      share_q    <= mprp_pkg::SHARE_RST;
      lfsr_q     <= mprp_pkg::SEED_RST;
    end else if (cfg_we_i) begin
      case (mprp_pkg::cfg_idx_e'(cfg_index_i))
        mprp_pkg::CFG_MATCH_ADDR:  match_q    <= cfg_data_i;
        mprp_pkg::CFG_FB_INTERVAL: interval_q <= cfg_data_i[6:0];
        mprp_pkg::CFG_PROBE_SHARE: share_q    <= cfg_data_i[6:0];
        mprp_pkg::CFG_RANDOM_SEED: lfsr_q     <= (cfg_data_i == '0) ? 32'd1 : cfg_data_i;
        default: ;
      endcase
    end else if (mod_start) begin
      lfsr_q <= lfsr_next;
    end
  end

  // Interval state: sent count, table, quotas, high/low toggle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q  <= '0;
      high_q  <= 1'b1;
      for (int i = 0; i < 4; i++) begin
        table_q[i] <= '0;
        quota_q[i] <= '0;
      end
    end else begin
      if (cmd_i.load && in_feedback_reset_i) begin
        sent_q <= '0;
      end else if (cmd_i.emit && matched_q && (sent_q < mprp_pkg::COUNT_MAX)) begin
        sent_q <= sent_q + 7'd1;
      end

      if (cmd_i.iv_init) begin
        quota_q[0] <= interval_q - q1x3;
        quota_q[1] <= 7'(q1_q);
        quota_q[2] <= 7'(q1_q);
        quota_q[3] <= 7'(q1_q);
        table_q[0] <= d_q;
        table_q[2] <= '0;
        table_q[3] <= '0;
        if (d_q == '0) begin
          table_q[1] <= RATE_W'(1);
        end else if (d_q == RATE_MAX) begin
          table_q[1] <= RATE_MAX - RATE_W'(1);
        end else begin
          table_q[1] <= d_q + RATE_W'(1);
          table_q[2] <= d_q - RATE_W'(1);
        end
      end else if (fill_wr) begin
        table_q[{1'b1, slot3_q}] <= cmd_i.fill_zero ? '0 : r_q;
        if (cmd_i.scan_sel && restricted_q) begin
          high_q <= !high_q;
        end
      end

      if (cmd_i.pick_take) begin
        quota_q[pick_sel] <= quota_q[pick_sel] - 7'd1;
      end
    end
  end

  // Per-packet working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      matched_q <= (in_protocol_i == mprp_pkg::UDP_PROTO) && (in_dest_addr_i == match_q);
      d_q       <= d_clamp;
      started_q <= 1'b0;
    end
    if (cmd_i.iv_mul) begin
      prod_q    <= 14'(share_c) * 14'(interval_q);
      started_q <= 1'b1;
    end
    if (cmd_i.iv_div100) begin
      q0_q <= 7'(m100 >> mprp_pkg::RECIP_100_SH);
    end
    if (cmd_i.iv_div3) begin
      q1_q <= 6'(m3 >> mprp_pkg::RECIP_3_SH);
    end

    // Slot and scan bookkeeping
    if (cmd_i.iv_init) begin
      slot3_q      <= !((d_q == '0) || (d_q == RATE_MAX));
      restricted_q <= !((d_q == '0) || (d_q == RATE_MAX) ||
                        (d_q == RATE_W'(1)) || (d_q == RATE_MAX - RATE_W'(1)));
    end else if (fill_wr) begin
      slot3_q <= 1'b1;
    end

    if (cmd_i.iv_init || fill_wr) begin
      r_q   <= '0;
      cnt_q <= '0;
    end else if (cmd_i.rnd_fill) begin
      r_q <= '0;
    end else if (cmd_i.scan_count) begin
      r_q   <= r_q + RATE_W'(1);
      cnt_q <= cnt_q + CNT_W'(elig);
    end else if (cmd_i.scan_sel) begin
      r_q <= r_q + RATE_W'(1);
    end

    if (mod_done) begin
      k_q <= mod_rem;
    end else if (cmd_i.scan_sel && elig && (k_q != '0)) begin
      k_q <= k_q - CNT_W'(1);
    end

    if (cmd_i.pick_default) begin
      rate_q <= table_q[0];
    end else if (cmd_i.pick_take) begin
      rate_q <= table_q[pick_sel];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_matched_q <= matched_q;
      out_rate_q    <= matched_q ? rate_q : '0;
      out_started_q <= matched_q && started_q;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_matched_o          = out_matched_q;
  assign out_send_rate_o        = 4'(out_rate_q);
  assign out_ip_id_value_o      = 16'(4'(out_rate_q)) << mprp_pkg::ID_SHIFT;
  assign out_interval_started_o = out_started_q;

  // Status to the sequencer
  always_comb begin
    sts_o              = '0;
    sts_o.matched      = matched_q;
    sts_o.interval_due = (sent_q == '0);
    sts_o.scan_last    = (r_q == RATE_MAX);
    sts_o.scan_hit     = hit;
    sts_o.cnt_zero     = (cnt_q == '0);
    sts_o.mod_done     = mod_done;
    sts_o.slot_last    = slot3_q;
    sts_o.pick_skip    = pick_skip;
    sts_o.out_free     = !out_valid_q || out_ready_i;
  end

`ifndef SYNTHESIS
  // LFSR must never lock up at zero
  a_lfsr_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != '0)
    else $error("LFSR reached zero");

  // A pick only spends quota that is there
  a_pick_quota: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pick_take |-> (quota_q[pick_sel] != '0))
    else $error("pick took an entry without quota");

  // Quotas of a new interval add up to the interval length
  a_quota_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.iv_init |=> ((8'(quota_q[0]) + 8'(quota_q[1]) + 8'(quota_q[2]) +
                        8'(quota_q[3])) == 8'(interval_q)))
    else $error("quota sum differs from interval");

  // Result only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote an untaken transfer");
`endif

endmodule

@@ rtl/multicast_probe_rate_picker_core.sv @@
// An unmatched packet goes straight to the output register; a matched one may wait on the
// remainder unit that reduces each random draw. Interval start adds quota arithmetic and
// one or two table fills. One packet in flight; the next input transfer is taken once the
// result is loaded, even while it waits. Reset (async, active low) restores config defaults
// and seed and clears control, sent count, table, quotas and output valid, not per-packet regs.
`timescale 1ns / 1ps

module multicast_probe_rate_picker_core #(
  parameter int MAX_RATE_INDEX = 15
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input packet events
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [47:0]                    s_axis_tdata,  // protocol, dest_addr, default_rate
  input  logic [0:0]                     s_axis_tuser,  // feedback_reset
  // results
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [23:0]                    m_axis_tdata,  // send_rate, ip_id_value
  output logic [1:0]                     m_axis_tuser,  // matched, interval_started
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [mprp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mprp_pkg::CFG_W-1:0]     cfg_data_i
);

  mprp_pkg::mprp_cmd_t cmd;
  mprp_pkg::mprp_sts_t sts;
  logic                out_matched;
  logic [3:0]          out_send_rate;
  logic [15:0]         out_ip_id_value;
  logic                out_started;

  mprp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mprp_dp #(
    .MAX_RATE_INDEX (MAX_RATE_INDEX)
  ) u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cmd_i                  (cmd),
    .sts_o                  (sts),
    .cfg_we_i               (cfg_we_i),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i),
    .in_protocol_i          (s_axis_tdata[7:0]),
    .in_dest_addr_i         (s_axis_tdata[39:8]),
    .in_default_rate_i      (s_axis_tdata[43:40]),
    .in_feedback_reset_i    (s_axis_tuser[0]),
    .out_ready_i            (m_axis_tready),
    .out_valid_o            (m_axis_tvalid),
    .out_matched_o          (out_matched),
    .out_send_rate_o        (out_send_rate),
    .out_ip_id_value_o      (out_ip_id_value),
    .out_interval_started_o (out_started)
  );

  // Pack result fields, lowest field first, zero fill to whole bytes
  assign m_axis_tdata = {4'b0000, out_ip_id_value, out_send_rate};
  assign m_axis_tuser = {out_started, out_matched};

endmodule
